// ===== sv/dwes_pkg.sv =====
// Shared widths, reset values and types of the damped wave stencil.
`timescale 1ns / 1ps

package dwes_pkg;

  // Field and register widths
  localparam int unsigned H_W        = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SPAN_W     = 10;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned DAMP_W     = 17;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  // Edge distance never exceeds the span register
  localparam int unsigned DIST_W     = SPAN_W;

  localparam int unsigned GRID_SIZE_DEF = 64;

  // Register reset values
  localparam logic [COEF_W-1:0]  COEF_A_RST  = 16'd16384;
  localparam logic [SPAN_W-1:0]  SPAN_RST    = 10'd63;
  localparam logic [SLOPE_W-1:0] SLOPE_RST   = 16'd9883;
  localparam logic [DAMP_W-1:0]  MAX_DAMP_RST = 17'd62259;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A      = 2'd0,
    CFG_SPAN_CELLS  = 2'd1,
    CFG_RAMP_SLOPE  = 2'd2,
    CFG_MAX_DAMPING = 2'd3
  } cfg_idx_e;

  // Coefficients used by the arithmetic pipeline
  typedef struct packed {
    logic [COEF_W-1:0]  coef_a;
    logic [SLOPE_W-1:0] ramp_slope;
    logic [DAMP_W-1:0]  max_damping;
  } coef_t;

  // Five-point neighborhood of one cell plus its previous height, edge distance and control flags
  typedef struct packed {
    logic signed [H_W-1:0] nh;
    logic signed [H_W-1:0] sh;
    logic signed [H_W-1:0] wh;
    logic signed [H_W-1:0] eh;
    logic signed [H_W-1:0] ch;
    logic signed [H_W-1:0] prev;
    logic [DIST_W-1:0]     edge_dist;
    logic                  border;
    logic                  frame_end;
  } nbr_t;

endpackage

// ===== sv/dwes_line_buf.sv =====
// Raster counters, line buffers and neighborhood capture stage.
`timescale 1ns / 1ps

module dwes_line_buf import dwes_pkg::*; #(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SPAN_W-1:0]     span_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [H_W-1:0] cur_height_i,
  input  logic signed [H_W-1:0] prev_height_i,
  output logic                  nbr_valid_o,
  input  logic                  nbr_ready_i,
  output nbr_t                  nbr_o
);

  localparam int unsigned CNT_W = $clog2(GRID_SIZE);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(GRID_SIZE - 1);

  logic [CNT_W-1:0] row_q, row_d, col_q, col_d;
  logic             valid_q;
  logic             load;
  logic             xfer;
  logic [CNT_W-1:0] e_addr;
  nbr_t             nbr_q;

  // Line buffers: row above current input, two rows above, previous heights
  logic signed [H_W-1:0] line1_mem [GRID_SIZE];
  logic signed [H_W-1:0] line2_mem [GRID_SIZE];
  logic signed [H_W-1:0] pline_mem [GRID_SIZE];

  logic signed [11:0] ri, cj, sp, d_a, d_b, d_m;
  logic [DIST_W-1:0]  cell_dist;
  logic               border, last_cell;

  // Take a new cell when the capture stage is empty or moving on
  assign load       = !valid_q || nbr_ready_i;
  assign xfer       = in_valid_i && load;
  assign in_stall_o = !load;

  // Advance the raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (xfer) begin
      if (col_q == LAST) begin
        col_d = '0;
        row_d = (row_q == LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Edge distance of the output cell (row above, same column)
  always_comb begin
    ri  = $signed(12'(row_q)) - 12'sd1;
    cj  = $signed(12'(col_q));
    sp  = $signed({2'b00, span_i});
    d_a = (ri < cj) ? ri : cj;
    d_b = ((sp - ri) < (sp - cj)) ? (sp - ri) : (sp - cj);
    d_m = (d_a < d_b) ? d_a : d_b;
    cell_dist = (d_m < 12'sd0) ? '0 : d_m[DIST_W-1:0];
  end

  assign border    = (row_q == CNT_W'(1)) || (col_q == '0) || (col_q == LAST);
  assign last_cell = (row_q == LAST) && (col_q == LAST);
  assign e_addr    = (col_q == LAST) ? '0 : col_q + 1'b1;

  // Capture the neighborhood and update the line buffers on a transfer
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      nbr_q.sh        <= cur_height_i;
      nbr_q.ch        <= line1_mem[col_q];
      nbr_q.nh        <= line2_mem[col_q];
      nbr_q.eh        <= line1_mem[e_addr];
      nbr_q.wh        <= nbr_q.ch;
      nbr_q.prev      <= pline_mem[col_q];
      nbr_q.edge_dist <= cell_dist;
      nbr_q.border    <= border;
      nbr_q.frame_end <= last_cell;
      line1_mem[col_q] <= cur_height_i;
      line2_mem[col_q] <= line1_mem[col_q];
      pline_mem[col_q] <= prev_height_i;
    end
  end

  // Row zero cells give no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= xfer && (row_q != '0);
    end
  end

  assign nbr_valid_o = valid_q;
  assign nbr_o       = nbr_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LAST) && (col_q <= LAST))
    else $error("raster counter out of range");

  a_last_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last_cell |=> valid_q && nbr_q.frame_end && nbr_q.border)
    else $error("last cell of the grid not captured as frame end");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last_cell |=> (row_q == '0) && (col_q == '0))
    else $error("raster position did not wrap after the last cell");

endmodule

// ===== sv/dwes_arith.sv =====
// Arithmetic pipeline: bracket, damping, rounding and saturation.
`timescale 1ns / 1ps

module dwes_arith import dwes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  coef_t                 coef_i,
  input  logic                  nbr_valid_i,
  output logic                  nbr_ready_o,
  input  nbr_t                  nbr_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [H_W-1:0] new_height_o,
  output logic                  frame_end_o
);

  // Stage valids and enables
  logic v2_q, v3_q, v4_q, v5_q, vo_q;
  logic en2, en3, en4, en5, eno;

  assign eno = !vo_q || !out_stall_i;
  assign en5 = !v5_q || eno;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign nbr_ready_o = en2;

  // Stage 2: neighbor sum and raw damping
  logic signed [17:0]     sum4_q;
  logic signed [H_W-1:0]  c2_q, p2_q;
  logic [25:0]            draw2_q;
  logic                   bd2_q, fe2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum4_q  <= 18'(nbr_i.nh) + 18'(nbr_i.sh) + 18'(nbr_i.wh) + 18'(nbr_i.eh);
      c2_q    <= nbr_i.ch;
      p2_q    <= nbr_i.prev;
      draw2_q <= nbr_i.edge_dist * coef_i.ramp_slope;
      bd2_q   <= nbr_i.border;
      fe2_q   <= nbr_i.frame_end;
    end
  end

  // Stage 3: coefficient products and damping clamp
  logic signed [19:0]     coef_b;
  logic signed [34:0]     ta3_q;
  logic signed [35:0]     tb3_q;
  logic signed [31:0]     tp3_q;
  logic [DAMP_W-1:0]      damp3_q;
  logic                   bd3_q, fe3_q;

  assign coef_b = 20'sd131072 - $signed({2'b00, coef_i.coef_a, 2'b00});

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ta3_q   <= $signed({1'b0, coef_i.coef_a}) * sum4_q;
      tb3_q   <= coef_b * c2_q;
      tp3_q   <= $signed({p2_q, 16'b0});
      damp3_q <= (draw2_q > 26'(coef_i.max_damping)) ? coef_i.max_damping
                                                     : draw2_q[DAMP_W-1:0];
      bd3_q   <= bd2_q;
      fe3_q   <= fe2_q;
    end
  end

  // Stage 4: bracket in Q.28
  logic signed [35:0]     brk4_q;
  logic [DAMP_W-1:0]      damp4_q;
  logic                   bd4_q, fe4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      brk4_q  <= 36'(ta3_q) + tb3_q - 36'(tp3_q);
      damp4_q <= damp3_q;
      bd4_q   <= bd3_q;
      fe4_q   <= fe3_q;
    end
  end

  // Stage 5: damping product as two partial products
  logic [34:0]            pl5_q;
  logic signed [35:0]     ph5_q;
  logic                   bd5_q, fe5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      pl5_q <= brk4_q[17:0] * damp4_q;
      ph5_q <= $signed(brk4_q[35:18]) * $signed({1'b0, damp4_q});
      bd5_q <= bd4_q;
      fe5_q <= fe4_q;
    end
  end

  // Output stage: join partials, round to nearest, saturate
  logic signed [53:0]     prod;
  logic signed [21:0]     res;
  logic signed [H_W-1:0]  sat;
  logic signed [H_W-1:0]  nh_q;
  logic                   feo_q;

  always_comb begin
    prod = $signed({ph5_q, 18'b0}) + $signed({19'b0, pl5_q}) + 54'sd2147483648;
    res  = prod[53:32];
    if (res > 22'sd32767) begin
      sat = 16'sh7fff;
    end else if (res < -22'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = res[H_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      nh_q  <= bd5_q ? '0 : sat;
      feo_q <= fe5_q;
    end
  end

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en2) v2_q <= nbr_valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (eno) vo_q <= v5_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign new_height_o = nh_q;
  assign frame_end_o  = feo_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nbr_ready_o |-> v2_q && v3_q && v4_q && v5_q && vo_q && out_stall_i)
    else $error("pipeline stalls with an empty stage");

  a_fe_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && feo_q |-> (nh_q == '0))
    else $error("frame end result is not a zero border cell");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !en5 |=> v5_q && $stable(pl5_q) && $stable(ph5_q))
    else $error("stalled stage lost its partial products");

endmodule

// ===== sv/damped_wave_equation_stencil_top.sv =====
// Damped 2-D wave equation stencil: a raster height stream in, next heights out.
//
// Usage: cells of a GRID_SIZE x GRID_SIZE grid enter in raster order on the
// input channel (cur_height_i, prev_height_i under in_valid_i / in_stall_o),
// one per cycle. Each cell of row r >= 1 yields one result on the output
// channel: the next height of the cell one row above, in Q4.12, saturated.
// Border cells give zero and frame_end_o marks the last emitted cell. Cells
// of row 0 yield nothing; the last grid row is never emitted.
// A result passes six register stages after its cell transfers: capture, four
// arithmetic stages and the output register.
// Throughput: one cell per cycle while in_stall_o is low, set by line buffers
// that are read and written once per transfer.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written by the user only
// while idle; the block does not enforce it. Reset clears the raster
// counters, the valid bits and loads the register defaults; the line buffers
// need no clearing. When the receiver stalls the result holds, stages fill up
// behind it, and in_stall_o rises only once every stage holds a result.
`timescale 1ns / 1ps

module damped_wave_equation_stencil_top import dwes_pkg::*; #(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [H_W-1:0] cur_height_i,
  input  logic signed [H_W-1:0] prev_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [H_W-1:0] new_height_o,
  output logic                  frame_end_o
);

  coef_t             coef_q;
  logic [SPAN_W-1:0] span_q;
  logic              nbr_valid, nbr_ready;
  nbr_t              nbr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.coef_a      <= COEF_A_RST;
      coef_q.ramp_slope  <= SLOPE_RST;
      coef_q.max_damping <= MAX_DAMP_RST;
      span_q             <= SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_A:      coef_q.coef_a      <= cfg_data_i[COEF_W-1:0];
        CFG_SPAN_CELLS:  span_q             <= cfg_data_i[SPAN_W-1:0];
        CFG_RAMP_SLOPE:  coef_q.ramp_slope  <= cfg_data_i[SLOPE_W-1:0];
        CFG_MAX_DAMPING: coef_q.max_damping <= cfg_data_i[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  dwes_line_buf #(
    .GRID_SIZE (GRID_SIZE)
  ) u_line_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .span_i        (span_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cur_height_i  (cur_height_i),
    .prev_height_i (prev_height_i),
    .nbr_valid_o   (nbr_valid),
    .nbr_ready_i   (nbr_ready),
    .nbr_o         (nbr)
  );

  dwes_arith u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef_q),
    .nbr_valid_i  (nbr_valid),
    .nbr_ready_o  (nbr_ready),
    .nbr_i        (nbr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_height_o (new_height_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
